// ===== rtl/core/csvn_pkg.sv =====
// ----------------------------------------------------------------------------
// csvn_pkg: shared definitions for the cosine smoothed value noise block
// Field widths, register and action codes, and the cosine weight table.
// ----------------------------------------------------------------------------
package csvn_pkg;

    localparam int MAX_WIDTH         = 64;
    localparam int MAX_HEIGHT        = 64;
    localparam int SAMPLE_BITS       = 16;
    localparam int WEIGHT_INDEX_BITS = 8;

    localparam int COL_BITS      = 6;
    localparam int ROW_BITS      = 6;
    localparam int DIM_BITS      = 7;
    localparam int OCT_BITS      = 3;
    localparam int OCTAVE_MAX    = 6;
    localparam int WEIGHT_BITS   = 16;
    localparam int WEIGHT_FRAC   = 16;
    localparam int WEIGHT_COUNT  = 1 << WEIGHT_INDEX_BITS;
    localparam int GRID_DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS     = ROW_BITS + COL_BITS;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 7;

    typedef logic [COL_BITS-1:0]          t_col;
    typedef logic [ROW_BITS-1:0]          t_row;
    typedef logic [DIM_BITS-1:0]          t_dim;
    typedef logic [OCT_BITS-1:0]          t_oct;
    typedef logic [SAMPLE_BITS-1:0]       t_sample;
    typedef logic [WEIGHT_BITS-1:0]       t_weight;
    typedef logic [WEIGHT_INDEX_BITS-1:0] t_widx;
    typedef logic [ADDR_BITS-1:0]         t_addr;
    typedef logic [CFG_ADDR_BITS-1:0]     t_cfg_addr;
    typedef logic [CFG_DATA_BITS-1:0]     t_cfg_data;
    typedef t_weight                      t_weight_rom [WEIGHT_COUNT];

    localparam t_cfg_addr CFG_GRID_WIDTH  = 2'd0;
    localparam t_cfg_addr CFG_GRID_HEIGHT = 2'd1;
    localparam t_cfg_addr CFG_OCTAVE      = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam t_dim DIM_RESET = 7'd64;
    localparam t_oct OCT_RESET = 3'd0;

    // Taylor divisors (2k)(2k+1) for k = 1..7
    localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;

    // sin^2 of the table angle, Q2.30 math, rounded to Q0.16
    function automatic t_weight weight_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] sq;
        logic [63:0] w;
        x    = (HALF_PI_Q30 * 64'(i)) >> WEIGHT_INDEX_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
            if (k % 2 == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        sq = (sum * sum) >> 30;
        w  = (sq + 64'd8192) >> 14;
        return (w > 64'd65535) ? t_weight'(16'hFFFF) : w[WEIGHT_BITS-1:0];
    endfunction

    function automatic t_weight_rom weight_rom_init();
        t_weight_rom rom;
        for (int i = 0; i < WEIGHT_COUNT; i++) begin
            rom[i] = weight_entry(i);
        end
        return rom;
    endfunction

    localparam t_weight_rom WEIGHT_ROM = weight_rom_init();

endpackage

// ===== rtl/core/csvn_in_if.sv =====
// ----------------------------------------------------------------------------
// csvn_in_if: input word channel
// Carries a sample write or a smoothed-value query.
// ----------------------------------------------------------------------------
interface csvn_in_if;
    import csvn_pkg::*;

    logic    valid;
    logic    ready;
    logic    action;
    t_col    col;
    t_row    row;
    t_sample sample;

    modport source (output valid, action, col, row, sample, input ready);
    modport sink   (input valid, action, col, row, sample, output ready);
endinterface

// ===== rtl/core/csvn_out_if.sv =====
// ----------------------------------------------------------------------------
// csvn_out_if: result word channel
// Carries the smoothed value and the out-of-range flag of one query.
// ----------------------------------------------------------------------------
interface csvn_out_if;
    import csvn_pkg::*;

    logic    valid;
    logic    ready;
    t_sample smoothed;
    logic    out_of_range;

    modport source (output valid, smoothed, out_of_range, input ready);
    modport sink   (input valid, smoothed, out_of_range, output ready);
endinterface

// ===== rtl/core/csvn_cfg_if.sv =====
// ----------------------------------------------------------------------------
// csvn_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface csvn_cfg_if;
    import csvn_pkg::*;

    logic      valid;
    logic      ready;
    t_cfg_addr addr;
    t_cfg_data wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== rtl/core/cosine_smoothed_value_noise.sv =====
// ----------------------------------------------------------------------------
// cosine_smoothed_value_noise: 2-D value noise with cosine interpolation
// Rough sample grid in one RAM; queries blend four lattice corners.
// ----------------------------------------------------------------------------
// A write word stores its sample at (row, col) of a 64x64 grid RAM; writes
// can stream at one per cycle while the block is idle. A query works out the
// corners and weights in S_ADDR, reads the four corners through the single
// RAM port in S_RD0..S_RD3 and blends them on the shared multiplier: the top
// pair in S_RD2, the bottom pair in S_BOT and the two rows in S_DONE. A query
// outside the configured grid goes straight to S_DONE. The next word is taken
// once the query has handed its result to the output register, which then holds
// it until the sink takes it. Configuration is to be written by the user only
// while the block is idle; the block itself does not enforce it.
module cosine_smoothed_value_noise (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csvn_in_if.sink       i_in,
    csvn_out_if.source    o_out,
    csvn_cfg_if.sink      i_cfg
);
    import csvn_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADDR = 3'd1;
    localparam logic [2:0] S_RD0  = 3'd2;
    localparam logic [2:0] S_RD1  = 3'd3;
    localparam logic [2:0] S_RD2  = 3'd4;
    localparam logic [2:0] S_RD3  = 3'd5;
    localparam logic [2:0] S_BOT  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    // (base + 2^oct) mod dim, base < dim
    function automatic t_dim next_corner(input t_dim base, input t_dim dim, input t_oct oct);
        t_dim              r;
        logic [DIM_BITS:0] s;
        r = (dim == t_dim'(1)) ? t_dim'(0) : t_dim'(1);
        for (int k = 0; k < OCTAVE_MAX; k++) begin
            if (k < int'(oct)) begin
                r = {r[DIM_BITS-2:0], 1'b0};
                if (r >= dim) begin
                    r = r - dim;
                end
            end
        end
        s = {1'b0, base} + {1'b0, r};
        if (s >= {1'b0, dim}) begin
            s = s - {1'b0, dim};
        end
        return s[DIM_BITS-1:0];
    endfunction

    // offset inside the cell scaled to the table index
    function automatic t_widx weight_idx(input t_col d, input t_oct oct);
        logic [COL_BITS+WEIGHT_INDEX_BITS-1:0] t;
        t = {d, {WEIGHT_INDEX_BITS{1'b0}}} >> oct;
        return t[WEIGHT_INDEX_BITS-1:0];
    endfunction

    logic [2:0] r_state, n_state;
    t_dim       r_cfg_width, r_cfg_height;
    t_oct       r_cfg_oct;

    t_col    r_col, r_x0, r_x1;
    t_row    r_row, r_y0, r_y1;
    t_dim    r_w, r_h;
    t_oct    r_oct;
    logic    r_oor;
    t_weight r_wx, r_wy;
    t_sample r_a, r_top, r_bot;
    logic    r_out_valid;
    t_sample r_smoothed;
    logic    r_out_oor;

    logic    in_acc, cfg_acc, out_free, ram_we;
    t_addr   ram_addr;
    t_sample ram_rdata;

    t_dim    eff_w, eff_h;
    t_oct    eff_oct;
    logic    in_oor;

    t_col    col_mask, x0_c, x1_c;
    t_row    row_mask, y0_c, y1_c;
    t_dim    x1_d, y1_d;

    t_sample                                  bl_lo, bl_hi, bl_out;
    t_weight                                  bl_w;
    logic signed [SAMPLE_BITS:0]              bl_diff;
    logic signed [SAMPLE_BITS+WEIGHT_BITS+1:0] bl_prod;

    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_out_valid;
    assign o_out.smoothed     = r_smoothed;
    assign o_out.out_of_range = r_out_oor;

    // clamped view of the registers
    always_comb begin
        if (r_cfg_width == '0) begin
            eff_w = t_dim'(1);
        end else if (r_cfg_width > t_dim'(MAX_WIDTH)) begin
            eff_w = t_dim'(MAX_WIDTH);
        end else begin
            eff_w = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            eff_h = t_dim'(1);
        end else if (r_cfg_height > t_dim'(MAX_HEIGHT)) begin
            eff_h = t_dim'(MAX_HEIGHT);
        end else begin
            eff_h = r_cfg_height;
        end
        eff_oct = (r_cfg_oct > t_oct'(OCTAVE_MAX)) ? t_oct'(OCTAVE_MAX) : r_cfg_oct;
        in_oor  = ({1'b0, i_in.col} >= eff_w) || ({1'b0, i_in.row} >= eff_h);
    end

    // lattice corners of the held query
    always_comb begin
        col_mask = COL_BITS'((t_dim'(1) << r_oct) - t_dim'(1));
        row_mask = ROW_BITS'((t_dim'(1) << r_oct) - t_dim'(1));
        x0_c     = r_col & ~col_mask;
        y0_c     = r_row & ~row_mask;
        x1_d     = next_corner({1'b0, x0_c}, r_w, r_oct);
        y1_d     = next_corner({1'b0, y0_c}, r_h, r_oct);
        x1_c     = x1_d[COL_BITS-1:0];
        y1_c     = y1_d[ROW_BITS-1:0];
    end

    // grid RAM port: writes in idle, corner reads during the query
    always_comb begin
        ram_we = in_acc && (i_in.action == ACT_WRITE);
        case (r_state)
            S_RD0:   ram_addr = {r_y0, r_x0};
            S_RD1:   ram_addr = {r_y0, r_x1};
            S_RD2:   ram_addr = {r_y1, r_x0};
            S_RD3:   ram_addr = {r_y1, r_x1};
            default: ram_addr = {i_in.row, i_in.col};
        endcase
    end

    csvn_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in.sample),
        .o_rdata (ram_rdata)
    );

    // shared blend: lo + floor((hi - lo) * w / 2^16)
    always_comb begin
        case (r_state)
            S_RD2, S_BOT: begin
                bl_lo = r_a;
                bl_hi = ram_rdata;
                bl_w  = r_wx;
            end
            default: begin
                bl_lo = r_top;
                bl_hi = r_bot;
                bl_w  = r_wy;
            end
        endcase
        bl_diff = $signed({1'b0, bl_hi}) - $signed({1'b0, bl_lo});
        bl_prod = bl_diff * $signed({1'b0, bl_w});
        // result stays within [lo, hi], so a modular add is exact
        bl_out  = bl_lo + bl_prod[WEIGHT_FRAC +: SAMPLE_BITS];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.action == ACT_QUERY) begin
                    n_state = in_oor ? S_DONE : S_ADDR;
                end
            end
            S_ADDR:  n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_RD3;
            S_RD3:   n_state = S_BOT;
            S_BOT:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_width  <= DIM_RESET;
            r_cfg_height <= DIM_RESET;
            r_cfg_oct    <= OCT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                case (i_cfg.addr)
                    CFG_GRID_WIDTH:  r_cfg_width  <= i_cfg.wdata;
                    CFG_GRID_HEIGHT: r_cfg_height <= i_cfg.wdata;
                    CFG_OCTAVE:      r_cfg_oct    <= i_cfg.wdata[OCT_BITS-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_col <= i_in.col;
                    r_row <= i_in.row;
                    r_w   <= eff_w;
                    r_h   <= eff_h;
                    r_oct <= eff_oct;
                    r_oor <= in_oor;
                end
            end
            S_ADDR: begin
                r_x0 <= x0_c;
                r_x1 <= x1_c;
                r_y0 <= y0_c;
                r_y1 <= y1_c;
                r_wx <= WEIGHT_ROM[weight_idx(r_col & col_mask, r_oct)];
                r_wy <= WEIGHT_ROM[weight_idx(COL_BITS'(r_row & row_mask), r_oct)];
            end
            S_RD1:   r_a   <= ram_rdata;
            S_RD2:   r_top <= bl_out;
            S_RD3:   r_a   <= ram_rdata;
            S_BOT:   r_bot <= bl_out;
            S_DONE: begin
                if (out_free) begin
                    r_smoothed <= r_oor ? t_sample'(0) : bl_out;
                    r_out_oor  <= r_oor;
                end
            end
            default: ;
        endcase
    end

    // grid is only written while no query is in flight
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("grid write outside idle");

    // a query always enters the corner or result path
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.action == ACT_QUERY) |=> (r_state == S_ADDR || r_state == S_DONE))
        else $error("query did not start");

    // a write word produces no result and keeps the block idle
    a_write_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.action == ACT_WRITE) |=> (r_state == S_IDLE))
        else $error("write word started a query");

    // out-of-range result carries a zero value
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_of_range) |-> (o_out.smoothed == '0))
        else $error("out-of-range result nonzero");

endmodule

// ===== rtl/core/csvn_ram.sv =====
// ----------------------------------------------------------------------------
// csvn_ram: single-port synchronous RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module csvn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
